[src/ldsk_pkg.sv]
// ldsk_pkg: shared widths, fixed-point constants, register codes and helpers
// for the lidar point deskew unit. No dependencies.
`timescale 1ns / 1ps

package ldsk_pkg;

   localparam int CORDIC_STAGES_DEF = 16;
   localparam int CORDIC_STAGES_MAX = 24;

   localparam int DATA_W  = 192;
   localparam int CSR_AW  = 5;
   localparam int FRAC_W  = 18;   // sweep fraction, signed Q2.16
   localparam int QUOT_W  = 18;
   localparam int DIV_LAT = QUOT_W + 3;
   localparam int ROT_W   = 17;   // angle register, sign-extended so it can be negated
   localparam int ANG_W   = 35;   // fraction times angle, Q29
   localparam int CRD_W   = 32;   // cordic datapath, Q3.29
   localparam int CS_W    = 26;   // sine and cosine, Q2.24
   localparam int COORD_W = 36;   // coordinates between rotations, Q16
   localparam int PROD_W  = CS_W + COORD_W;

   localparam logic signed [FRAC_W-1:0] FRAC_MAX = 18'sd131071;
   localparam logic signed [FRAC_W-1:0] FRAC_MIN = -18'sd131072;

   localparam logic signed [ANG_W-1:0] PI_Q29      = 35'sd1686629713;
   localparam logic signed [ANG_W-1:0] TWO_PI_Q29  = 35'sd3373259426;
   localparam logic signed [CRD_W-1:0] HALF_PI_Q29 = 32'sd843314857;
   localparam logic signed [CRD_W-1:0] CORDIC_GAIN = 32'sd326016437;

   typedef enum logic [2:0] {
      REG_ROT_X       = 3'd0,
      REG_ROT_Y       = 3'd1,
      REG_ROT_Z       = 3'd2,
      REG_SHIFT_X     = 3'd3,
      REG_SHIFT_Y     = 3'd4,
      REG_SHIFT_Z     = 3'd5,
      REG_SWEEP_START = 3'd6,
      REG_SWEEP_END   = 3'd7
   } csr_reg_type;

   // arctangent of 2^-i in Q29 radians
   function automatic logic signed [CRD_W-1:0] atan_q29(input int unsigned idx);
      case (idx)
         0:  atan_q29 = 32'sd421657428;
         1:  atan_q29 = 32'sd248918915;
         2:  atan_q29 = 32'sd131521918;
         3:  atan_q29 = 32'sd66762579;
         4:  atan_q29 = 32'sd33510843;
         5:  atan_q29 = 32'sd16771758;
         6:  atan_q29 = 32'sd8387925;
         7:  atan_q29 = 32'sd4194219;
         8:  atan_q29 = 32'sd2097141;
         9:  atan_q29 = 32'sd1048575;
         10: atan_q29 = 32'sd524288;
         11: atan_q29 = 32'sd262144;
         12: atan_q29 = 32'sd131072;
         13: atan_q29 = 32'sd65536;
         14: atan_q29 = 32'sd32768;
         15: atan_q29 = 32'sd16384;
         16: atan_q29 = 32'sd8192;
         17: atan_q29 = 32'sd4096;
         18: atan_q29 = 32'sd2048;
         19: atan_q29 = 32'sd1024;
         20: atan_q29 = 32'sd512;
         21: atan_q29 = 32'sd256;
         22: atan_q29 = 32'sd128;
         23: atan_q29 = 32'sd64;
         default: atan_q29 = 32'sd0;
      endcase
   endfunction

   function automatic logic [31:0] sat32(input logic signed [COORD_W-1:0] v);
      if (v > 36'sd2147483647) begin
         sat32 = 32'h7fff_ffff;
      end else if (v < -36'sd2147483648) begin
         sat32 = 32'h8000_0000;
      end else begin
         sat32 = v[31:0];
      end
   endfunction

endpackage

[src/ldsk_delay.sv]
// ldsk_delay: enable-gated shift line that keeps side data in step with the
// arithmetic pipeline. No dependencies.
`timescale 1ns / 1ps

module ldsk_delay #(
   parameter int unsigned WIDTH = 1,
   parameter int unsigned DEPTH = 1
) (
   input  logic             clock,
   input  logic             en,
   input  logic [WIDTH-1:0] din,
   output logic [WIDTH-1:0] dout
);

   logic [WIDTH-1:0] tap_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (en) begin
         tap_ff[0] <= din;
         for (int i = 1; i < DEPTH; i++) begin
            tap_ff[i] <= tap_ff[i-1];
         end
      end
   end

   assign dout = tap_ff[DEPTH-1];

endmodule

[src/ldsk_sdiv.sv]
// ldsk_sdiv: pipelined restoring divider giving the saturated sweep fraction
// (time - start) / (end - start) in signed Q2.16. Uses ldsk_pkg.
`timescale 1ns / 1ps

module ldsk_sdiv (
   input  logic                              clock,
   input  logic                              en,
   input  logic [31:0]                       point_time,
   input  logic [31:0]                       sweep_start,
   input  logic [31:0]                       sweep_end,
   output logic signed [ldsk_pkg::FRAC_W-1:0] frac
);

   localparam int QW    = ldsk_pkg::QUOT_W;
   localparam int REM_W = 33 + 16 + 3;

   logic signed [32:0] num_in;
   logic signed [32:0] den_in;
   logic [32:0]        nmag_in;
   logic [32:0]        dmag_in;

   logic [32:0] nmag0_ff;
   logic [32:0] dmag0_ff;
   logic        neg0_ff;
   logic        zero0_ff;

   logic [REM_W-1:0] rem_ff  [QW+1];
   logic [32:0]      dmag_ff [QW+1];
   logic [QW-1:0]    q_ff    [QW+1];
   logic             neg_ff  [QW+1];
   logic             zero_ff [QW+1];
   logic             ovf_ff  [QW+1];

   logic signed [ldsk_pkg::FRAC_W-1:0] frac_in;
   logic signed [ldsk_pkg::FRAC_W-1:0] frac_ff;

   always_comb begin
      num_in  = $signed({1'b0, point_time}) - $signed({1'b0, sweep_start});
      den_in  = $signed({1'b0, sweep_end}) - $signed({1'b0, sweep_start});
      nmag_in = num_in[32] ? 33'(-num_in) : 33'(num_in);
      dmag_in = den_in[32] ? 33'(-den_in) : 33'(den_in);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         nmag0_ff <= nmag_in;
         dmag0_ff <= dmag_in;
         neg0_ff  <= num_in[32] ^ den_in[32];
         zero0_ff <= (den_in == 33'sd0);
         // quotient of 2^18 or more always saturates
         ovf_ff[0]  <= REM_W'({nmag0_ff, 16'b0}) >= REM_W'({dmag0_ff, 18'b0});
         rem_ff[0]  <= REM_W'({nmag0_ff, 16'b0});
         dmag_ff[0] <= dmag0_ff;
         q_ff[0]    <= '0;
         neg_ff[0]  <= neg0_ff;
         zero_ff[0] <= zero0_ff;
      end
   end

   for (genvar j = 0; j < QW; j++) begin : g_step
      localparam int K = QW - 1 - j;
      logic [REM_W-1:0] dsh;
      logic             fits;
      assign dsh  = REM_W'(dmag_ff[j]) << K;
      assign fits = rem_ff[j] >= dsh;
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j+1]  <= fits ? rem_ff[j] - dsh : rem_ff[j];
            q_ff[j+1]    <= {q_ff[j][QW-2:0], fits};
            dmag_ff[j+1] <= dmag_ff[j];
            neg_ff[j+1]  <= neg_ff[j];
            zero_ff[j+1] <= zero_ff[j];
            ovf_ff[j+1]  <= ovf_ff[j];
         end
      end
   end

   always_comb begin
      if (zero_ff[QW]) begin
         frac_in = '0;
      end else if (!neg_ff[QW]) begin
         frac_in = (ovf_ff[QW] || q_ff[QW] > 18'd131071) ? ldsk_pkg::FRAC_MAX
                                                         : $signed(q_ff[QW]);
      end else begin
         frac_in = (ovf_ff[QW] || q_ff[QW] > 18'd131072) ? ldsk_pkg::FRAC_MIN
                                                         : -$signed(q_ff[QW]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         frac_ff <= frac_in;
      end
   end

   assign frac = frac_ff;

endmodule

[src/ldsk_sincos.sv]
// ldsk_sincos: angle product, range reduction and pipelined rotation-mode
// cordic giving cosine and sine in Q2.24. Uses ldsk_pkg.
`timescale 1ns / 1ps

module ldsk_sincos #(
   parameter int STAGES = ldsk_pkg::CORDIC_STAGES_DEF
) (
   input  logic                               clock,
   input  logic                               en,
   input  logic signed [ldsk_pkg::FRAC_W-1:0] frac,
   input  logic signed [ldsk_pkg::ROT_W-1:0]  rot,
   output logic signed [ldsk_pkg::CS_W-1:0]   cos_q,
   output logic signed [ldsk_pkg::CS_W-1:0]   sin_q
);

   localparam int AW = ldsk_pkg::ANG_W;
   localparam int CW = ldsk_pkg::CRD_W;

   logic signed [AW-1:0] ang_in;
   logic signed [AW-1:0] ang_ff;
   logic signed [CW-1:0] wrap_in;
   logic signed [CW-1:0] wrap_ff;

   logic signed [CW-1:0] x_ff [STAGES+1];
   logic signed [CW-1:0] y_ff [STAGES+1];
   logic signed [CW-1:0] z_ff [STAGES+1];
   logic                 flip_ff [STAGES+1];

   logic signed [CW-1:0] xr;
   logic signed [CW-1:0] yr;
   logic signed [ldsk_pkg::CS_W-1:0] cos_ff;
   logic signed [ldsk_pkg::CS_W-1:0] sin_ff;

   assign ang_in = frac * rot;

   // one turn at most is ever needed for the largest product
   always_comb begin
      if (ang_ff > ldsk_pkg::PI_Q29) begin
         wrap_in = CW'(ang_ff - ldsk_pkg::TWO_PI_Q29);
      end else if (ang_ff < -ldsk_pkg::PI_Q29) begin
         wrap_in = CW'(ang_ff + ldsk_pkg::TWO_PI_Q29);
      end else begin
         wrap_in = CW'(ang_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ang_ff  <= ang_in;
         wrap_ff <= wrap_in;
         x_ff[0] <= ldsk_pkg::CORDIC_GAIN;
         y_ff[0] <= '0;
         if (wrap_ff > ldsk_pkg::HALF_PI_Q29) begin
            z_ff[0]    <= wrap_ff - CW'(ldsk_pkg::PI_Q29);
            flip_ff[0] <= 1'b1;
         end else if (wrap_ff < -ldsk_pkg::HALF_PI_Q29) begin
            z_ff[0]    <= wrap_ff + CW'(ldsk_pkg::PI_Q29);
            flip_ff[0] <= 1'b1;
         end else begin
            z_ff[0]    <= wrap_ff;
            flip_ff[0] <= 1'b0;
         end
      end
   end

   for (genvar i = 0; i < STAGES; i++) begin : g_cordic
      always_ff @(posedge clock) begin
         if (en) begin
            if (!z_ff[i][CW-1]) begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - ldsk_pkg::atan_q29(i);
            end else begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + ldsk_pkg::atan_q29(i);
            end
            flip_ff[i+1] <= flip_ff[i];
         end
      end
   end

   assign xr = (x_ff[STAGES] + 32'sd16) >>> 5;
   assign yr = (y_ff[STAGES] + 32'sd16) >>> 5;

   always_ff @(posedge clock) begin
      if (en) begin
         cos_ff <= flip_ff[STAGES] ? -ldsk_pkg::CS_W'(xr) : ldsk_pkg::CS_W'(xr);
         sin_ff <= flip_ff[STAGES] ? -ldsk_pkg::CS_W'(yr) : ldsk_pkg::CS_W'(yr);
      end
   end

   assign cos_q = cos_ff;
   assign sin_q = sin_ff;

endmodule

[src/ldsk_rotate.sv]
// ldsk_rotate: two-stage planar rotation, products then rounded sums, Q16 in
// and out. Uses ldsk_pkg.
`timescale 1ns / 1ps

module ldsk_rotate (
   input  logic                                clock,
   input  logic                                en,
   input  logic signed [ldsk_pkg::COORD_W-1:0] a,
   input  logic signed [ldsk_pkg::COORD_W-1:0] b,
   input  logic signed [ldsk_pkg::CS_W-1:0]    cos_q,
   input  logic signed [ldsk_pkg::CS_W-1:0]    sin_q,
   output logic signed [ldsk_pkg::COORD_W-1:0] na,
   output logic signed [ldsk_pkg::COORD_W-1:0] nb
);

   localparam int PW = ldsk_pkg::PROD_W;
   localparam int SW = PW + 1;

   logic signed [PW-1:0] ca_ff;
   logic signed [PW-1:0] sb_ff;
   logic signed [PW-1:0] sa_ff;
   logic signed [PW-1:0] cb_ff;
   logic signed [SW-1:0] suma;
   logic signed [SW-1:0] sumb;
   logic signed [ldsk_pkg::COORD_W-1:0] na_ff;
   logic signed [ldsk_pkg::COORD_W-1:0] nb_ff;

   // round half up from Q40 down to Q16
   assign suma = (SW'(ca_ff) - SW'(sb_ff) + (SW'(1) <<< 23)) >>> 24;
   assign sumb = (SW'(sa_ff) + SW'(cb_ff) + (SW'(1) <<< 23)) >>> 24;

   always_ff @(posedge clock) begin
      if (en) begin
         ca_ff <= cos_q * a;
         sb_ff <= sin_q * b;
         sa_ff <= sin_q * a;
         cb_ff <= cos_q * b;
         na_ff <= suma[ldsk_pkg::COORD_W-1:0];
         nb_ff <= sumb[ldsk_pkg::COORD_W-1:0];
      end
   end

   assign na = na_ff;
   assign nb = nb_ff;

endmodule

[src/lidar_point_deskew_unit.sv]
// lidar_point_deskew_unit: top level of the lidar point deskew pipeline.
// Uses ldsk_pkg, ldsk_delay, ldsk_sdiv, ldsk_sincos and ldsk_rotate.
`timescale 1ns / 1ps
//
//   channel   direction  handshake         contents
//   req_*     in         tvalid / tready   one point per transfer
//   rsp_*     out        tvalid / tready   one deskewed point per transfer
//   csr_*     in         psel / penable    eight pose and sweep registers
//
// one point per cycle while the skid register is empty; the path runs divider,
// cordic with the translate alongside, three rotations, then the output register.
// the whole pipeline moves on one enable; an output register plus a skid
// register take the result side, and req_tready drops only when both are full.
// reset is synchronous and clears the valid line, output flags and registers.

module lidar_point_deskew_unit #(
   parameter int CORDIC_STAGES = ldsk_pkg::CORDIC_STAGES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // in_x, in_y, in_z, point_time, aux_a, aux_b (32 bits each)
   input  logic [ldsk_pkg::DATA_W-1:0] req_tdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // out_x, out_y, out_z, out_time, out_aux_a, out_aux_b (32 bits each)
   output logic [ldsk_pkg::DATA_W-1:0] rsp_tdata,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [ldsk_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [31:0]                 csr_pwdata,
   output logic [31:0]                 csr_prdata,
   output logic                        csr_pready
);

   localparam int CW  = ldsk_pkg::COORD_W;
   localparam int FW  = ldsk_pkg::FRAC_W;
   localparam int RW  = ldsk_pkg::ROT_W;
   localparam int LAT = ldsk_pkg::DIV_LAT + CORDIC_STAGES + 10;

   logic [15:0] rot_x_ff, rot_y_ff, rot_z_ff;
   logic [31:0] shift_x_ff, shift_y_ff, shift_z_ff;
   logic [31:0] sweep_start_ff, sweep_end_ff;
   ldsk_pkg::csr_reg_type csr_idx;
   logic        csr_wr;

   logic        en;
   logic        accept;
   logic [LAT-1:0] vld_ff;

   logic [95:0] pt_d;
   logic signed [FW-1:0] frac;
   logic signed [FW-1:0] frac_d2;
   logic signed [FW-1:0] frac_d4;

   logic signed [31:0] px1_ff, py1_ff, pz1_ff;
   logic signed [49:0] tx_ff, ty_ff, tz_ff;
   logic signed [CW-1:0] ptx_ff, pty_ff, ptz_ff;
   logic signed [49:0] rtx, rty, rtz;
   logic [3*CW-1:0] pt_al;

   logic signed [ldsk_pkg::CS_W-1:0] cz, sz, cx, sx, cy, sy;
   logic signed [RW-1:0] rot_z_neg, rot_x_neg, rot_y_pos;

   logic signed [CW-1:0] x1, y1, z1, y2, z2, x2, x3, z3, y3;

   logic [95:0] side_d;
   logic [ldsk_pkg::DATA_W-1:0] pipe_data;
   logic        pipe_take;

   logic        out_valid_ff;
   logic [ldsk_pkg::DATA_W-1:0] out_data_ff;
   logic        skid_valid_ff;
   logic [ldsk_pkg::DATA_W-1:0] skid_data_ff;

   // register file
   assign csr_idx    = ldsk_pkg::csr_reg_type'(csr_paddr[ldsk_pkg::CSR_AW-1:2]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rot_x_ff       <= '0;
         rot_y_ff       <= '0;
         rot_z_ff       <= '0;
         shift_x_ff     <= '0;
         shift_y_ff     <= '0;
         shift_z_ff     <= '0;
         sweep_start_ff <= '0;
         sweep_end_ff   <= '0;
      end else if (csr_wr) begin
         case (csr_idx)
            ldsk_pkg::REG_ROT_X:       rot_x_ff       <= csr_pwdata[15:0];
            ldsk_pkg::REG_ROT_Y:       rot_y_ff       <= csr_pwdata[15:0];
            ldsk_pkg::REG_ROT_Z:       rot_z_ff       <= csr_pwdata[15:0];
            ldsk_pkg::REG_SHIFT_X:     shift_x_ff     <= csr_pwdata;
            ldsk_pkg::REG_SHIFT_Y:     shift_y_ff     <= csr_pwdata;
            ldsk_pkg::REG_SHIFT_Z:     shift_z_ff     <= csr_pwdata;
            ldsk_pkg::REG_SWEEP_START: sweep_start_ff <= csr_pwdata;
            ldsk_pkg::REG_SWEEP_END:   sweep_end_ff   <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         ldsk_pkg::REG_ROT_X:       csr_prdata = {16'b0, rot_x_ff};
         ldsk_pkg::REG_ROT_Y:       csr_prdata = {16'b0, rot_y_ff};
         ldsk_pkg::REG_ROT_Z:       csr_prdata = {16'b0, rot_z_ff};
         ldsk_pkg::REG_SHIFT_X:     csr_prdata = shift_x_ff;
         ldsk_pkg::REG_SHIFT_Y:     csr_prdata = shift_y_ff;
         ldsk_pkg::REG_SHIFT_Z:     csr_prdata = shift_z_ff;
         ldsk_pkg::REG_SWEEP_START: csr_prdata = sweep_start_ff;
         ldsk_pkg::REG_SWEEP_END:   csr_prdata = sweep_end_ff;
         default:                   csr_prdata = '0;
      endcase
   end

   // pipeline control
   assign en         = !skid_valid_ff;
   assign req_tready = en;
   assign accept     = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[LAT-2:0], accept};
      end
   end

   // sweep fraction
   ldsk_sdiv u_div (
      .clock       (clock),
      .en          (en),
      .point_time  (req_tdata[127:96]),
      .sweep_start (sweep_start_ff),
      .sweep_end   (sweep_end_ff),
      .frac        (frac)
   );

   ldsk_delay #(.WIDTH(96), .DEPTH(ldsk_pkg::DIV_LAT)) u_pt_dly (
      .clock (clock),
      .en    (en),
      .din   (req_tdata[95:0]),
      .dout  (pt_d)
   );

   // translation: product, then rounded subtract
   assign rtx = (tx_ff + 50'sd32768) >>> 16;
   assign rty = (ty_ff + 50'sd32768) >>> 16;
   assign rtz = (tz_ff + 50'sd32768) >>> 16;

   always_ff @(posedge clock) begin
      if (en) begin
         px1_ff   <= $signed(pt_d[31:0]);
         py1_ff   <= $signed(pt_d[63:32]);
         pz1_ff   <= $signed(pt_d[95:64]);
         tx_ff    <= frac * $signed(shift_x_ff);
         ty_ff    <= frac * $signed(shift_y_ff);
         tz_ff    <= frac * $signed(shift_z_ff);
         ptx_ff   <= CW'(px1_ff) - CW'(rtx);
         pty_ff   <= CW'(py1_ff) - CW'(rty);
         ptz_ff   <= CW'(pz1_ff) - CW'(rtz);
      end
   end

   ldsk_delay #(.WIDTH(3*CW), .DEPTH(CORDIC_STAGES + 2)) u_al_dly (
      .clock (clock),
      .en    (en),
      .din   ({ptz_ff, pty_ff, ptx_ff}),
      .dout  (pt_al)
   );

   // angles: z and x turn the other way
   assign rot_z_neg = -RW'($signed(rot_z_ff));
   assign rot_x_neg = -RW'($signed(rot_x_ff));
   assign rot_y_pos = RW'($signed(rot_y_ff));

   ldsk_delay #(.WIDTH(FW), .DEPTH(2)) u_fx_dly (
      .clock (clock),
      .en    (en),
      .din   (frac),
      .dout  (frac_d2)
   );

   ldsk_delay #(.WIDTH(FW), .DEPTH(2)) u_fy_dly (
      .clock (clock),
      .en    (en),
      .din   (frac_d2),
      .dout  (frac_d4)
   );

   ldsk_sincos #(.STAGES(CORDIC_STAGES)) u_sc_z (
      .clock (clock), .en (en), .frac (frac), .rot (rot_z_neg),
      .cos_q (cz), .sin_q (sz)
   );

   ldsk_sincos #(.STAGES(CORDIC_STAGES)) u_sc_x (
      .clock (clock), .en (en), .frac (frac_d2), .rot (rot_x_neg),
      .cos_q (cx), .sin_q (sx)
   );

   ldsk_sincos #(.STAGES(CORDIC_STAGES)) u_sc_y (
      .clock (clock), .en (en), .frac (frac_d4), .rot (rot_y_pos),
      .cos_q (cy), .sin_q (sy)
   );

   // rotation about z on (x, y)
   ldsk_rotate u_rot_z (
      .clock (clock), .en (en),
      .a (pt_al[CW-1:0]), .b (pt_al[2*CW-1:CW]),
      .cos_q (cz), .sin_q (sz), .na (x1), .nb (y1)
   );

   ldsk_delay #(.WIDTH(CW), .DEPTH(2)) u_z1_dly (
      .clock (clock), .en (en), .din (pt_al[3*CW-1:2*CW]), .dout (z1)
   );

   // rotation about x on (y, z)
   ldsk_rotate u_rot_x (
      .clock (clock), .en (en), .a (y1), .b (z1),
      .cos_q (cx), .sin_q (sx), .na (y2), .nb (z2)
   );

   ldsk_delay #(.WIDTH(CW), .DEPTH(2)) u_x2_dly (
      .clock (clock), .en (en), .din (x1), .dout (x2)
   );

   // rotation about y on (x, z)
   ldsk_rotate u_rot_y (
      .clock (clock), .en (en), .a (x2), .b (z2),
      .cos_q (cy), .sin_q (sy), .na (x3), .nb (z3)
   );

   ldsk_delay #(.WIDTH(CW), .DEPTH(2)) u_y3_dly (
      .clock (clock), .en (en), .din (y2), .dout (y3)
   );

   // time and auxiliary words ride along untouched
   ldsk_delay #(.WIDTH(96), .DEPTH(LAT)) u_side_dly (
      .clock (clock),
      .en    (en),
      .din   (req_tdata[191:96]),
      .dout  (side_d)
   );

   assign pipe_data = {side_d, ldsk_pkg::sat32(z3), ldsk_pkg::sat32(y3),
                       ldsk_pkg::sat32(x3)};
   assign pipe_take = vld_ff[LAT-1] && en;

   // output register with skid
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_tready) begin
            out_data_ff   <= skid_data_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (pipe_take) begin
         if (!out_valid_ff || rsp_tready) begin
            out_valid_ff <= 1'b1;
            out_data_ff  <= pipe_data;
         end else begin
            skid_valid_ff <= 1'b1;
            skid_data_ff  <= pipe_data;
         end
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

[src/ldsk_checker.sv]
// ldsk_checker: port-level assertions for lidar_point_deskew_unit, bound to it
// below. Uses ldsk_pkg for port widths.
`timescale 1ns / 1ps

module ldsk_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_tready,
   input logic                        rsp_tvalid,
   input logic                        rsp_tready,
   input logic [ldsk_pkg::DATA_W-1:0] rsp_tdata,
   input logic                        csr_pready
);

   // a held result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   // a held result keeps its data
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("result data changed while stalled");

   // input side only backs off when a result is waiting
   a_ready_backs_off: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("ready low with no result pending");

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // register port never waits
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_pready)
      else $error("register port not ready");

endmodule

bind lidar_point_deskew_unit ldsk_checker u_ldsk_checker (.*);
